// ===== rtl/btmx_pkg.sv =====
package btmx_pkg;

    localparam int KEY_W = 31;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;
    localparam logic [1:0] OP_NOP    = 2'd3;

    typedef struct packed {
        logic idle;
        logic accept;
        logic walk;
        logic check;
        logic link_wr;
        logic build_wr;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic in_valid;
        logic in_walk;
        logic brk;
        logic last;
        logic fail;
        logic out_free;
    } status_t;

endpackage

// ===== rtl/btmx_req_if.sv =====
interface btmx_req_if;
    import btmx_pkg::*;

    logic             valid;
    logic             ready;
    logic [1:0]       op;
    logic [KEY_W-1:0] key;

    modport source (output valid, output op, output key, input ready);
    modport sink   (input valid, input op, input key, output ready);
endinterface

// ===== rtl/btmx_rsp_if.sv =====
interface btmx_rsp_if;
    import btmx_pkg::*;

    logic             valid;
    logic             ready;
    logic [KEY_W-1:0] max_xor;
    logic             full_error;

    modport source (output valid, output max_xor, output full_error, input ready);
    modport sink   (input valid, input max_xor, input full_error, output ready);
endinterface

// ===== rtl/btmx_ram.sv =====
module btmx_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/btmx_ctrl.sv =====
module btmx_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  btmx_pkg::status_t st,
    output btmx_pkg::cmd_t    cmd
);
    import btmx_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_WALK   = 6'b000010,
        S_CHECK  = 6'b000100,
        S_LINK   = 6'b001000,
        S_BUILD  = 6'b010000,
        S_FINISH = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (st.in_valid)
                begin
                    state_next = st.in_walk ? S_WALK : S_FINISH;
                end
            end
            S_WALK:
            begin
                if (st.brk)
                begin
                    state_next = S_CHECK;
                end
                else if (st.last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_CHECK:
            begin
                state_next = st.fail ? S_FINISH : S_LINK;
            end
            S_LINK:
            begin
                state_next = S_BUILD;
            end
            S_BUILD:
            begin
                if (st.last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (st.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd.idle     = (state_reg == S_IDLE);
        cmd.accept   = (state_reg == S_IDLE) && st.in_valid;
        cmd.walk     = (state_reg == S_WALK);
        cmd.check    = (state_reg == S_CHECK);
        cmd.link_wr  = (state_reg == S_LINK);
        cmd.build_wr = (state_reg == S_BUILD);
        cmd.finish   = (state_reg == S_FINISH) && st.out_free;
    end
endmodule

// ===== rtl/btmx_dp.sv =====
module btmx_dp #(
    parameter int NODE_COUNT = 65536,
    parameter int KEY_BITS   = 31
) (
    input  logic              clk,
    input  logic              rst_n,
    btmx_req_if.sink          req,
    btmx_rsp_if.source        rsp,
    input  btmx_pkg::cmd_t    cmd,
    output btmx_pkg::status_t st
);
    import btmx_pkg::*;

    localparam int NODE_W = $clog2(NODE_COUNT);
    localparam int LVL_W  = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
    localparam int NF_W   = NODE_W + 1;
    localparam int SUM_W  = NODE_W + 2;
    localparam logic [LVL_W-1:0] TOP_LVL = LVL_W'(KEY_BITS - 1);

    logic [1:0]          op_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [KEY_BITS-1:0] acc_reg;
    logic [LVL_W-1:0]    level_reg;
    logic [NODE_W-1:0]   node_reg;
    logic [NODE_W-1:0]   root0_reg;
    logic [NODE_W-1:0]   root1_reg;
    logic [NODE_W-1:0]   brk0_reg;
    logic [NODE_W-1:0]   brk1_reg;
    logic [NF_W-1:0]     nf_reg;
    logic                full_reg;
    logic                out_valid_reg;
    logic [KEY_W-1:0]    out_max_reg;
    logic                out_full_reg;

    logic [2*NODE_W-1:0] ram_rdata;
    logic [2*NODE_W-1:0] ram_wdata;
    logic [NODE_W-1:0]   ram_raddr;
    logic [NODE_W-1:0]   ram_waddr;
    logic                ram_we;

    logic                is_insert;
    logic                is_query;
    logic                bit_now;
    logic                bit_below;
    logic [NODE_W-1:0]   link0;
    logic [NODE_W-1:0]   link1;
    logic [NODE_W-1:0]   other;
    logic [NODE_W-1:0]   same;
    logic                take_other;
    logic [NODE_W-1:0]   nx;
    logic [NODE_W-1:0]   fresh;
    logic [NODE_W-1:0]   child;
    logic [SUM_W-1:0]    need_sum;
    logic                out_free;

    btmx_ram #(
        .WIDTH (2 * NODE_W),
        .DEPTH (NODE_COUNT)
    ) u_links (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // The root lives in flip-flops so that a clear takes effect at once.
    always_comb
    begin
        is_insert  = (op_reg == OP_INSERT);
        is_query   = (op_reg == OP_QUERY);
        bit_now    = key_reg[level_reg];
        bit_below  = key_reg[level_reg - LVL_W'(1)];
        link0      = (node_reg == '0) ? root0_reg : ram_rdata[NODE_W-1:0];
        link1      = (node_reg == '0) ? root1_reg : ram_rdata[2*NODE_W-1:NODE_W];
        other      = bit_now ? link0 : link1;
        same       = bit_now ? link1 : link0;
        take_other = is_query && (other != '0);
        nx         = take_other ? other : same;
        fresh      = nf_reg[NODE_W-1:0];
        child      = NODE_W'(nf_reg + NF_W'(1));
        need_sum   = SUM_W'({1'b0, level_reg}) + SUM_W'(1) + SUM_W'(nf_reg);
        out_free   = !out_valid_reg || rsp.ready;
    end

    always_comb
    begin
        ram_raddr = nx;
        ram_we    = (cmd.link_wr && (node_reg != '0)) || cmd.build_wr;
        ram_waddr = cmd.link_wr ? node_reg : fresh;
        if (cmd.link_wr)
        begin
            ram_wdata = bit_now ? {fresh, brk0_reg} : {brk1_reg, fresh};
        end
        else if (level_reg == '0)
        begin
            ram_wdata = '0;
        end
        else
        begin
            ram_wdata = bit_below ? {child, {NODE_W{1'b0}}} : {{NODE_W{1'b0}}, child};
        end
    end

    always_comb
    begin
        st.in_valid = req.valid;
        st.in_walk  = (req.op == OP_INSERT) || (req.op == OP_QUERY);
        st.brk      = is_insert && (same == '0);
        st.last     = (level_reg == '0);
        st.fail     = need_sum > SUM_W'(NODE_COUNT);
        st.out_free = out_free;
    end

    assign req.ready      = cmd.idle;
    assign rsp.valid      = out_valid_reg;
    assign rsp.max_xor    = out_max_reg;
    assign rsp.full_error = out_full_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root0_reg     <= '0;
            root1_reg     <= '0;
            nf_reg        <= NF_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept && (req.op == OP_CLEAR))
            begin
                root0_reg <= '0;
                root1_reg <= '0;
                nf_reg    <= NF_W'(1);
            end
            if (cmd.link_wr && (node_reg == '0))
            begin
                if (bit_now)
                begin
                    root1_reg <= fresh;
                end
                else
                begin
                    root0_reg <= fresh;
                end
            end
            if (cmd.build_wr)
            begin
                nf_reg <= nf_reg + NF_W'(1);
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg    <= req.op;
            key_reg   <= KEY_BITS'(req.key);
            acc_reg   <= '0;
            level_reg <= TOP_LVL;
            node_reg  <= '0;
            full_reg  <= 1'b0;
        end
        if (cmd.walk)
        begin
            if (st.brk)
            begin
                brk0_reg <= link0;
                brk1_reg <= link1;
            end
            else
            begin
                node_reg           <= nx;
                acc_reg[level_reg] <= take_other;
                if (level_reg != '0)
                begin
                    level_reg <= level_reg - LVL_W'(1);
                end
            end
        end
        if (cmd.check)
        begin
            full_reg <= st.fail;
        end
        if (cmd.build_wr && (level_reg != '0))
        begin
            level_reg <= level_reg - LVL_W'(1);
        end
        if (cmd.finish)
        begin
            out_max_reg  <= KEY_W'(acc_reg);
            out_full_reg <= full_reg;
        end
    end

`ifndef SYNTH
    a_nf_bound: assert property (@(posedge clk) disable iff (!rst_n)
        nf_reg <= NF_W'(NODE_COUNT))
        else $error("free node index ran past the node store");

    a_build_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.build_wr |-> (nf_reg < NF_W'(NODE_COUNT)))
        else $error("node allocated with no room left");

    a_no_root_write: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (ram_waddr != '0))
        else $error("root node written into the link memory");

    a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !(rsp.full_error && (rsp.max_xor != '0)))
        else $error("result carries both a query answer and a full flag");
`endif
endmodule

// ===== rtl/binary_trie_max_xor_top.sv =====
// Binary trie engine over KEY_BITS-bit keys that answers maximum-XOR queries. Each transfer
// on req carries one operation (clear, insert, query, or the unused code, which does
// nothing) and produces exactly one transfer on rsp. A clear or unused code goes straight
// from accepting the transfer to its last step. A query walks the trie level by level,
// and each level needs one dependent read of the node link memory. An insert of a key
// that is already stored only walks its path. An insert that builds new nodes walks the
// existing path down to where it breaks off, makes one capacity check, does one write to
// hook the new branch onto the trie, and does one memory write per new node. An insert
// that would need more nodes than remain of the NODE_COUNT-entry store is dropped whole
// and answers full_error = 1. The root is held in flip-flops and every node is written
// when it is allocated, so the block is ready right after reset with no clearing pass. A
// new transfer is accepted once the previous result has moved into the output register.
// When that register still holds a result that rsp has not taken, the block waits in its
// last step.
module binary_trie_max_xor_top #(
    parameter int NODE_COUNT = 65536,
    parameter int KEY_BITS   = 31
) (
    input  logic       clk,
    input  logic       rst_n,
    btmx_req_if.sink   req,
    btmx_rsp_if.source rsp
);
    import btmx_pkg::*;

    cmd_t    cmd;
    status_t st;

    btmx_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .st    (st),
        .cmd   (cmd)
    );

    btmx_dp #(
        .NODE_COUNT (NODE_COUNT),
        .KEY_BITS   (KEY_BITS)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cmd   (cmd),
        .st    (st)
    );
endmodule
